### rtl/assert_macros.svh
// Assertion macros shared by the RTL; clocked on clk, disabled while rst is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge out of reset
`define CNMS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after its antecedent
`define CNMS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

### rtl/cnms_pkg.sv
// Shared types, constants and functions for the Canny non-maximum suppression block
`timescale 1ns / 1ps

package cnms_pkg;

  localparam int DEF_MAX_WIDTH = 1024;
  localparam int DEF_MAG_BITS  = 16;

  localparam int DIR_BITS          = 10;
  localparam int CLASS_BITS        = 2;
  localparam int FRAME_WIDTH_BITS  = 11;
  localparam int ROW_BITS          = 16;
  localparam int THRESH_BITS       = 16;
  localparam int CFG_IDX_BITS      = 2;
  localparam int CFG_DATA_BITS     = 16;

  localparam logic [FRAME_WIDTH_BITS-1:0] RST_FRAME_WIDTH    = 11'd640;
  localparam logic [ROW_BITS-1:0]         RST_FRAME_HEIGHT   = 16'd480;
  localparam logic [THRESH_BITS-1:0]      RST_HIGH_THRESHOLD = 16'd1120;
  localparam logic [THRESH_BITS-1:0]      RST_LOW_THRESHOLD  = 16'd16;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_FRAME_WIDTH    = 2'd0,
    CFG_FRAME_HEIGHT   = 2'd1,
    CFG_HIGH_THRESHOLD = 2'd2,
    CFG_LOW_THRESHOLD  = 2'd3
  } cfg_index_t;

  typedef enum logic [CLASS_BITS-1:0] {
    EDGE_NONE   = 2'd0,
    EDGE_WEAK   = 2'd1,
    EDGE_STRONG = 2'd2
  } edge_class_t;

  typedef enum logic [1:0] {
    BIN_HORIZ = 2'd0,
    BIN_DIAG  = 2'd1,
    BIN_VERT  = 2'd2,
    BIN_ANTI  = 2'd3
  } dir_bin_t;

  // bin edges in half degrees (22.5, 67.5, ... degrees)
  localparam logic [DIR_BITS-1:0] ANG_22  = 10'd45;
  localparam logic [DIR_BITS-1:0] ANG_67  = 10'd135;
  localparam logic [DIR_BITS-1:0] ANG_112 = 10'd225;
  localparam logic [DIR_BITS-1:0] ANG_157 = 10'd315;
  localparam logic [DIR_BITS-1:0] ANG_202 = 10'd405;
  localparam logic [DIR_BITS-1:0] ANG_247 = 10'd495;
  localparam logic [DIR_BITS-1:0] ANG_292 = 10'd585;
  localparam logic [DIR_BITS-1:0] ANG_337 = 10'd675;

  function automatic dir_bin_t dir_bin(input logic [DIR_BITS-1:0] d);
    dir_bin_t b;
    if (d <= ANG_22 || (d > ANG_157 && d <= ANG_202) || d > ANG_337) begin
      b = BIN_HORIZ;
    end else if (d <= ANG_67 || (d > ANG_202 && d <= ANG_247)) begin
      b = BIN_DIAG;
    end else if (d <= ANG_112 || (d > ANG_247 && d <= ANG_292)) begin
      b = BIN_VERT;
    end else begin
      b = BIN_ANTI;
    end
    return b;
  endfunction

endpackage

### rtl/cnms_if.sv
// Valid/ready stream interfaces for gradient pixels and edge results
`timescale 1ns / 1ps

interface cnms_pixel_if import cnms_pkg::*; #(
  parameter int MAG_BITS = DEF_MAG_BITS
) ();
  logic                valid;
  logic                ready;
  logic [MAG_BITS-1:0] magnitude;
  logic [DIR_BITS-1:0] direction;
  logic                start_of_frame;

  modport source (output valid, magnitude, direction, start_of_frame, input ready);
  modport sink   (input valid, magnitude, direction, start_of_frame, output ready);
endinterface

interface cnms_result_if import cnms_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CLASS_BITS-1:0] edge_class;
  logic                  last_in_frame;

  modport source (output valid, edge_class, last_in_frame, input ready);
  modport sink   (input valid, edge_class, last_in_frame, output ready);
endinterface

### rtl/canny_nonmax_suppression_top.sv
// Canny non-maximum suppression with double threshold, streaming top level
//
//   channel  dir  payload                                   transfer
//   pixel    in   magnitude, direction, start_of_frame      valid & ready
//   result   out  edge_class, last_in_frame                 valid & ready
//   cfg      in   cfg_index, cfg_data                       cfg_write
//
// One pixel per clock sustained while the result side keeps up. A pixel is read from the
// line memory on the cycle it transfers and is written back when stage 1 moves on; the
// result register loads then, and its result shows in the cycle after.
// After rst the line memory is cleared, with pixel.ready low until every column is written.
// A stalled result holds stage 1 and the pixel input; border pixels never stall.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module canny_nonmax_suppression_top import cnms_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int MAG_BITS  = DEF_MAG_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  cnms_pixel_if.sink               pixel,
  cnms_result_if.source            result,
  input  logic                     cfg_write,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = ROW_BITS + 1;
  localparam int MEM_W = 2 * MAG_BITS + DIR_BITS;
  localparam int TW    = (MAG_BITS > THRESH_BITS) ? MAG_BITS : THRESH_BITS;

  // configuration
  logic [FRAME_WIDTH_BITS-1:0] frame_width;
  logic [ROW_BITS-1:0]         frame_height;
  logic [THRESH_BITS-1:0]      high_threshold;
  logic [THRESH_BITS-1:0]      low_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width    <= RST_FRAME_WIDTH;
      frame_height   <= RST_FRAME_HEIGHT;
      high_threshold <= RST_HIGH_THRESHOLD;
      low_threshold  <= RST_LOW_THRESHOLD;
    end else if (cfg_write) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_FRAME_WIDTH:    frame_width    <= cfg_data[FRAME_WIDTH_BITS-1:0];
        CFG_FRAME_HEIGHT:   frame_height   <= cfg_data[ROW_BITS-1:0];
        CFG_HIGH_THRESHOLD: high_threshold <= cfg_data[THRESH_BITS-1:0];
        CFG_LOW_THRESHOLD:  low_threshold  <= cfg_data[THRESH_BITS-1:0];
      endcase
    end
  end

  // saturated geometry
  logic [WW-1:0] w_sat;
  logic [HW-1:0] h_sat;

  always_comb begin
    if (frame_width < FRAME_WIDTH_BITS'(3)) begin
      w_sat = WW'(3);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      w_sat = WW'(MAX_WIDTH);
    end else begin
      w_sat = WW'(frame_width);
    end
    if (frame_height < ROW_BITS'(3)) begin
      h_sat = HW'(3);
    end else begin
      h_sat = HW'(frame_height);
    end
  end

  // clearing pass over the line memory
  logic          clearing;
  logic [AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == AW'(MAX_WIDTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // stage 0: position of the incoming pixel
  logic          in_accept;
  logic [AW-1:0] col_cnt;
  logic [ROW_BITS-1:0] row_cnt;
  logic [AW-1:0] pos_col;
  logic [HW-1:0] pos_row;
  logic [WW-1:0] col_inc;
  logic [HW-1:0] row_inc;
  logic [AW-1:0] col_cnt_next;
  logic [HW-1:0] row_cnt_next;
  logic          has_out0;
  logic          last0;

  always_comb begin
    pos_col = pixel.start_of_frame ? '0 : col_cnt;
    pos_row = pixel.start_of_frame ? '0 : HW'(row_cnt);
    if (WW'(pos_col) >= w_sat) begin
      pos_col = '0;
      pos_row = pos_row + HW'(1);
    end
    if (pos_row >= h_sat) begin
      pos_row = '0;
    end
    col_inc = WW'(pos_col) + WW'(1);
    row_inc = pos_row + HW'(1);
    if (col_inc >= w_sat) begin
      col_cnt_next = '0;
      row_cnt_next = (row_inc >= h_sat) ? '0 : row_inc;
    end else begin
      col_cnt_next = col_inc[AW-1:0];
      row_cnt_next = pos_row;
    end
    has_out0 = (pos_row >= HW'(2)) && (WW'(pos_col) >= WW'(2));
    last0    = (pos_row == h_sat - HW'(1)) && (WW'(pos_col) == w_sat - WW'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (in_accept) begin
      col_cnt <= col_cnt_next;
      row_cnt <= row_cnt_next[ROW_BITS-1:0];
    end
  end

  // stage 1 registers
  logic                s1_valid;
  logic                s1_go;
  logic [AW-1:0]       s1_col;
  logic [MAG_BITS-1:0] s1_mag;
  logic [DIR_BITS-1:0] s1_dir;
  logic                s1_out;
  logic                s1_last;

  assign pixel.ready = !clearing && (!s1_valid || s1_go);
  assign in_accept   = pixel.valid && pixel.ready;
  assign s1_go       = s1_valid && (!s1_out || !result.valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_col  <= pos_col;
      s1_mag  <= pixel.magnitude;
      s1_dir  <= pixel.direction;
      s1_out  <= has_out0;
      s1_last <= last0;
    end
  end

  // line memory: {older magnitude, newer magnitude, angle} per column
  logic [MEM_W-1:0]    line_mem [MAX_WIDTH];
  logic [MEM_W-1:0]    rd_word;
  logic [MEM_W-1:0]    wr_word;
  logic                fwd;
  logic [MAG_BITS-1:0] rd_older;
  logic [MAG_BITS-1:0] rd_newer;
  logic [DIR_BITS-1:0] rd_angle;

  assign rd_older = rd_word[MEM_W-1 -: MAG_BITS];
  assign rd_newer = rd_word[DIR_BITS +: MAG_BITS];
  assign rd_angle = rd_word[DIR_BITS-1:0];
  assign wr_word  = {rd_newer, s1_mag, s1_dir};
  // back-to-back hits on one column (start of frame twice) take the write data
  assign fwd      = s1_go && (s1_col == pos_col);

  always_ff @(posedge clk) begin
    if (clearing) begin
      line_mem[clr_addr] <= '0;
    end else if (s1_go) begin
      line_mem[s1_col] <= wr_word;
    end
    if (in_accept) begin
      rd_word <= fwd ? wr_word : line_mem[pos_col];
    end
  end

  // 3x3 window, row-major: 0..2 top, 3..5 middle, 6..8 bottom
  logic [MAG_BITS-1:0] win      [9];
  logic [MAG_BITS-1:0] win_next [9];
  logic [DIR_BITS-1:0] centre_angle;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_next[r*3]     = win[r*3+1];
      win_next[r*3 + 1] = win[r*3+2];
    end
    win_next[2] = rd_older;
    win_next[5] = rd_newer;
    win_next[8] = s1_mag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) begin
        win[i] <= '0;
      end
      centre_angle <= '0;
    end else if (s1_go) begin
      win          <= win_next;
      centre_angle <= rd_angle;
    end
  end

  // suppression and double threshold
  logic [MAG_BITS-1:0] ctr;
  logic [MAG_BITS-1:0] nb1;
  logic [MAG_BITS-1:0] nb2;
  edge_class_t         cls;

  always_comb begin
    ctr = win_next[4];
    unique case (dir_bin(centre_angle))
      BIN_HORIZ: begin nb1 = win_next[3]; nb2 = win_next[5]; end
      BIN_DIAG:  begin nb1 = win_next[0]; nb2 = win_next[8]; end
      BIN_VERT:  begin nb1 = win_next[1]; nb2 = win_next[7]; end
      BIN_ANTI:  begin nb1 = win_next[2]; nb2 = win_next[6]; end
    endcase
    cls = EDGE_NONE;
    if (ctr > nb1 && ctr > nb2) begin
      if (TW'(ctr) > TW'(high_threshold)) begin
        cls = EDGE_STRONG;
      end else if (TW'(ctr) > TW'(low_threshold)) begin
        cls = EDGE_WEAK;
      end
    end
  end

  // output register
  logic                  out_valid;
  logic [CLASS_BITS-1:0] out_class;
  logic                  out_last;
  logic                  out_load;

  assign out_load = s1_go && s1_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_class <= cls;
      out_last  <= s1_last;
    end
  end

  assign result.valid         = out_valid;
  assign result.edge_class    = out_class;
  assign result.last_in_frame = out_last;

  `CNMS_ASSERT(a_no_pixel_while_clearing, !(clearing && pixel.ready), "pixel taken during clear")
  `CNMS_ASSERT(a_result_slot_free, !out_load || !result.valid || result.ready, "result overwritten")
  `CNMS_ASSERT_NEXT(a_forward_word, in_accept && fwd, rd_word == $past(wr_word), "forward missed")
  `CNMS_ASSERT(a_clear_full_sweep, !$fell(clearing) || $past(clr_addr) == AW'(MAX_WIDTH - 1), "clear cut short")

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// Testbench for canny_nonmax_suppression_top: edge predictor, stimulus and result checks

import cnms_pkg::*;

typedef struct packed {
  edge_class_t cls;
  logic        last;
} edge_result_t;

class edge_predictor;
  localparam int HALF_TURN = 360;
  localparam int FULL_TURN = 720;
  localparam int MARK_22   = 45;
  localparam int MARK_67   = 135;
  localparam int MARK_112  = 225;
  localparam int MARK_157  = 315;
  localparam int LINE_MAX  = DEF_MAX_WIDTH;

  logic [15:0] mag_prev2 [LINE_MAX];
  logic [15:0] mag_prev1 [LINE_MAX];
  logic [9:0]  dir_prev  [LINE_MAX];
  logic [15:0] win [9];
  logic [9:0]  centre_dir;
  int          col_pos;
  int          row_pos;

  logic [10:0] width_reg;
  logic [15:0] height_reg;
  logic [15:0] hi_thr;
  logic [15:0] lo_thr;

  edge_result_t expected_edges [$];
  int           mismatches;

  function new();
    foreach (mag_prev2[i]) begin
      mag_prev2[i] = '0;
      mag_prev1[i] = '0;
      dir_prev[i]  = '0;
    end
    foreach (win[i]) win[i] = '0;
    centre_dir = '0;
    col_pos    = 0;
    row_pos    = 0;
    width_reg  = RST_FRAME_WIDTH;
    height_reg = RST_FRAME_HEIGHT;
    hi_thr     = RST_HIGH_THRESHOLD;
    lo_thr     = RST_LOW_THRESHOLD;
    mismatches = 0;
  endfunction

  function void set_reg(cfg_index_t idx, logic [15:0] val);
    case (idx)
      CFG_FRAME_WIDTH:    width_reg  = val[10:0];
      CFG_FRAME_HEIGHT:   height_reg = val;
      CFG_HIGH_THRESHOLD: hi_thr     = val;
      CFG_LOW_THRESHOLD:  lo_thr     = val;
      default: ;
    endcase
  endfunction

  function int line_len();
    int w;
    w = width_reg;
    if (w < 3) w = 3;
    if (w > LINE_MAX) w = LINE_MAX;
    return w;
  endfunction

  function int frame_lines();
    int h;
    h = height_reg;
    if (h < 3) h = 3;
    return h;
  endfunction

  // opposite directions share a bin, so fold into one half turn first
  function dir_bin_t quantize(logic [9:0] d);
    int a;
    a = d;
    if (a >= FULL_TURN) return BIN_HORIZ;
    if (a >= HALF_TURN) a = a - HALF_TURN;
    if (a <= MARK_22 || a > MARK_157) return BIN_HORIZ;
    if (a <= MARK_67) return BIN_DIAG;
    if (a <= MARK_112) return BIN_VERT;
    return BIN_ANTI;
  endfunction

  function void note_pixel(logic [15:0] mag, logic [9:0] dir, logic sof);
    int           w;
    int           h;
    int           k;
    logic [9:0]   above;
    logic [15:0]  ctr;
    logic [15:0]  n1;
    logic [15:0]  n2;
    edge_result_t r;
    w = line_len();
    h = frame_lines();
    if (sof) begin
      col_pos = 0;
      row_pos = 0;
    end
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;

    for (k = 0; k < 3; k++) begin
      win[3*k]   = win[3*k+1];
      win[3*k+1] = win[3*k+2];
    end
    win[2] = mag_prev2[col_pos];
    win[5] = mag_prev1[col_pos];
    win[8] = mag;
    mag_prev2[col_pos] = mag_prev1[col_pos];
    mag_prev1[col_pos] = mag;
    above = dir_prev[col_pos];
    dir_prev[col_pos] = dir;

    if (row_pos >= 2 && col_pos >= 2) begin
      ctr = win[4];
      case (quantize(centre_dir))
        BIN_HORIZ: begin n1 = win[3]; n2 = win[5]; end
        BIN_DIAG:  begin n1 = win[0]; n2 = win[8]; end
        BIN_VERT:  begin n1 = win[1]; n2 = win[7]; end
        default:   begin n1 = win[2]; n2 = win[6]; end
      endcase
      r.cls = EDGE_NONE;
      if (ctr > n1 && ctr > n2) begin
        if (ctr > hi_thr) r.cls = EDGE_STRONG;
        else if (ctr > lo_thr) r.cls = EDGE_WEAK;
      end
      r.last = (row_pos == h - 1) && (col_pos == w - 1);
      expected_edges.push_back(r);
    end

    centre_dir = above;
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
  endfunction

  function int pending();
    return expected_edges.size();
  endfunction

  function void check_edge(logic [1:0] cls, logic last);
    edge_result_t e;
    if (expected_edges.size() == 0) begin
      $display("%0t: unexpected result transfer: edge_class expected none got %0d, last %0d",
               $time, cls, last);
      mismatches++;
      return;
    end
    e = expected_edges.pop_front();
    if (cls !== e.cls) begin
      $display("%0t: edge_class expected %0d got %0d", $time, e.cls, cls);
      mismatches++;
    end
    if (last !== e.last) begin
      $display("%0t: last_in_frame expected %0d got %0d", $time, e.last, last);
      mismatches++;
    end
  endfunction
endclass

module tb;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WIDE_LINE      = DEF_MAX_WIDTH;

  logic                     clk;
  logic                     rst;
  logic                     cfg_write;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  cnms_pixel_if  pix ();
  cnms_result_if res ();

  canny_nonmax_suppression_top dut (
    .clk       (clk),
    .rst       (rst),
    .pixel     (pix),
    .result    (res),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  edge_predictor edges;
  bit            steady;
  int            ready_hold = 0;
  int            quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] pick_mag();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 16'hFFFF;
    if (r < 10) return 16'h0000;
    if (r < 55) return 16'($urandom_range(0, 31));
    if (r < 80) return 16'($urandom_range(0, 2047));
    return 16'($urandom);
  endfunction

  function automatic logic [9:0] pick_dir();
    int r;
    int bin_marks [18];
    bin_marks = '{0, 45, 46, 135, 136, 225, 226, 315, 316,
                  405, 406, 495, 496, 585, 586, 675, 676, 719};
    r = $urandom_range(0, 99);
    if (r < 15) return 10'(bin_marks[$urandom_range(0, 17)]);
    if (r < 25) return 10'($urandom_range(720, 1023));
    return 10'($urandom_range(0, 719));
  endfunction

  // result side back-pressure
  always @(negedge clk) begin
    if (ready_hold > 0) begin
      res.ready = 1'b0;
      ready_hold--;
    end else begin
      res.ready = 1'b1;
      ready_hold = pick_gap();
    end
  end

  always @(posedge clk) begin
    if (!rst && res.valid === 1'b1 && res.ready === 1'b1) begin
      edges.check_edge(res.edge_class, res.last_in_frame);
    end
  end

  always @(posedge clk) begin
    if ((pix.valid === 1'b1 && pix.ready === 1'b1) ||
        (res.valid === 1'b1 && res.ready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, edges.pending());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // called at a falling edge; returns at a falling edge
  task automatic write_reg(cfg_index_t idx, logic [15:0] val);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    edges.set_reg(idx, val);
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic load_settings(int w, int h, int hi, int lo);
    write_reg(CFG_FRAME_WIDTH, 16'(w));
    write_reg(CFG_FRAME_HEIGHT, 16'(h));
    write_reg(CFG_HIGH_THRESHOLD, 16'(hi));
    write_reg(CFG_LOW_THRESHOLD, 16'(lo));
  endtask

  task automatic send_pixel(logic [15:0] mag, logic [9:0] dir, logic sof);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      pix.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    pix.valid          = 1'b1;
    pix.magnitude      = mag;
    pix.direction      = dir;
    pix.start_of_frame = sof;
    do @(posedge clk); while (pix.ready !== 1'b1);
    edges.note_pixel(mag, dir, sof);
    @(negedge clk);
  endtask

  // hold the sender until every result is in, then let the pipeline empty
  task automatic settle();
    pix.valid = 1'b0;
    while (edges.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // mostly whole frames; some cut short by an early start of frame, some with none
  task automatic stream_frames(int total, bit lead_no_sof);
    int w;
    int h;
    int len;
    int sent;
    int i;
    int r;
    bit with_sof;
    w = edges.line_len();
    h = edges.frame_lines();
    sent = 0;
    while (sent < total) begin
      r = $urandom_range(0, 99);
      with_sof = !(lead_no_sof && sent == 0) && r < 85;
      len = w * h;
      if (with_sof && r >= 70) len = $urandom_range(1, w * h - 1);
      if (len > total - sent) len = total - sent;
      for (i = 0; i < len; i++) begin
        send_pixel(pick_mag(), pick_dir(), with_sof && i == 0);
      end
      sent += len;
    end
  endtask

  initial begin
    int p;
    int w_val;
    int h_val;
    int hi_val;
    int lo_val;
    int r;
    int dmag [16];
    int ddir [16];

    rst                = 1'b1;
    cfg_write          = 1'b0;
    cfg_index          = CFG_FRAME_WIDTH;
    cfg_data           = '0;
    pix.valid          = 1'b0;
    pix.magnitude      = '0;
    pix.direction      = '0;
    pix.start_of_frame = 1'b0;
    steady             = 1'b0;
    edges              = new();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // 4x4 frame: strong, weak, not a maximum, and equal to the low threshold,
    // one interior pixel in each direction bin
    load_settings(4, 4, 1000, 100);
    dmag = '{0, 10, 20, 30,
             5, 65535, 500, 0,
             1, 200, 100, 40,
             3, 0, 2, 65535};
    ddir = '{0, 0, 0, 0,
             0, 45, 46, 1023,
             719, 180, 300, 720,
             512, 0, 0, 0};
    for (p = 0; p < 16; p++) send_pixel(16'(dmag[p]), 10'(ddir[p]), p == 0);
    settle();

    // geometry below range saturates to 3x3; no start of frame; centre
    // direction out of range must fall in the horizontal bin
    load_settings(2, 0, 65535, 0);
    dmag = '{65535, 65535, 65535, 1, 65535, 2, 65535, 65535, 65535,
             0, 0, 0, 0, 0, 0, 0};
    for (p = 0; p < 9; p++) begin
      send_pixel(16'(dmag[p]), (p == 4) ? 10'd1000 : 10'(p * 100), 1'b0);
    end
    settle();

    // widest line, stopped part way into the second line
    load_settings(2047, 3, 65535, 0);
    for (p = 0; p < WIDE_LINE + 24; p++) send_pixel(pick_mag(), pick_dir(), p == 0);
    settle();

    // random settings; the first two phases pick up mid frame after the
    // geometry shrank, so position wraps on both column and row
    for (p = 0; p < 8; p++) begin
      r = $urandom_range(0, 99);
      if (r < 70) w_val = $urandom_range(3, 8);
      else if (r < 90) w_val = $urandom_range(9, 40);
      else w_val = $urandom_range(0, 2);
      r = $urandom_range(0, 99);
      if (r < 80) h_val = $urandom_range(3, 8);
      else if (r < 90) h_val = $urandom_range(0, 2);
      else h_val = 65535;
      if (p == 0) begin
        w_val = 5;
        h_val = 65535;
      end
      if (p == 1) h_val = 3;
      r = $urandom_range(0, 99);
      if (r < 10) hi_val = 0;
      else if (r < 20) hi_val = 65535;
      else hi_val = $urandom_range(16, 1500);
      r = $urandom_range(0, 99);
      if (r < 15) lo_val = 0;
      else if (r < 25) lo_val = 65535;
      else lo_val = $urandom_range(0, 24);
      steady = ($urandom_range(0, 3) == 0);
      load_settings(w_val, h_val, hi_val, lo_val);
      stream_frames(72, p < 2 || $urandom_range(0, 99) < 15);
      settle();
    end

    if (edges.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
